// ----- rtl/mmlsc_pkg.sv -----
// Package for the multi-motor limit-stop controller.
// Holds item kind codes, field widths, the per-item result struct and the duty magnitude function.
// No dependencies.
package mmlsc_pkg;

  localparam int MOTOR_W   = 3;
  localparam int DUTY_W    = 18;
  localparam int MAG_W     = 17;
  localparam int POS_W     = 32;
  localparam int COMPARE_W = 10;

  localparam logic [MAG_W-1:0] DUTY_FULL         = 17'h10000;
  localparam logic [POS_W-1:0] RESET_DESTINATION = 32'd100;

  typedef enum logic [1:0] {
    KIND_SET_DUTY_DIR = 2'd0,
    KIND_SET_DUTY     = 2'd1,
    KIND_SET_DEST     = 2'd2,
    KIND_TICK         = 2'd3
  } kind_t;

  // Outcome of one transaction on the addressed motor, after its update.
  typedef struct packed {
    logic             in_range;
    logic [MAG_W-1:0] magnitude;
    logic             forward;
    logic             stopped;
  } bank_result_t;

  // |duty| saturated at full scale. The most negative code negates to 2^17,
  // which still fits the unsigned 18-bit view and saturates like the rest.
  function automatic logic [MAG_W-1:0] duty_magnitude_of(input logic [DUTY_W-1:0] raw);
    logic [DUTY_W-1:0] abs_val;
    abs_val = raw[DUTY_W-1] ? (~raw + 18'd1) : raw;
    if (abs_val > {1'b0, DUTY_FULL}) begin
      return DUTY_FULL;
    end
    return abs_val[MAG_W-1:0];
  endfunction

endpackage

// ----- rtl/mmlsc_motor_bank.sv -----
// Per-motor state registers and their read-modify-write update.
// Depends on mmlsc_pkg for kind codes, widths and the result struct.
module mmlsc_motor_bank #(
  parameter int MOTOR_COUNT = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                update,
  input  logic                                position_stop_enable,
  input  mmlsc_pkg::kind_t                    kind,
  input  logic [mmlsc_pkg::MOTOR_W-1:0]       motor,
  input  logic [mmlsc_pkg::DUTY_W-1:0]        duty,
  input  logic [mmlsc_pkg::POS_W-1:0]         target_position,
  input  logic [mmlsc_pkg::POS_W-1:0]         encoder_count,
  input  logic                                limit_near,
  input  logic                                limit_far,
  output mmlsc_pkg::bank_result_t             result
);

  logic [mmlsc_pkg::MAG_W-1:0] duty_magnitude      [MOTOR_COUNT];
  logic                        pin_forward         [MOTOR_COUNT];
  logic                        travel_forward      [MOTOR_COUNT];
  logic [mmlsc_pkg::POS_W-1:0] destination         [MOTOR_COUNT];
  logic                        approach_from_below [MOTOR_COUNT];

  logic [MOTOR_COUNT-1:0]      sel;
  logic                        in_range;

  logic [mmlsc_pkg::MAG_W-1:0] cur_mag;
  logic                        cur_pin;
  logic                        cur_trav;
  logic [mmlsc_pkg::POS_W-1:0] cur_dest;
  logic                        cur_afb;

  logic [mmlsc_pkg::MAG_W-1:0] mag_next;
  logic                        pin_next;
  logic                        trav_next;
  logic [mmlsc_pkg::POS_W-1:0] dest_next;
  logic                        afb_next;
  logic                        stop;
  logic                        limit_hit;
  logic                        reached;

  // Decode the motor field and read the addressed entry.
  always_comb begin
    cur_mag  = '0;
    cur_pin  = 1'b0;
    cur_trav = 1'b0;
    cur_dest = '0;
    cur_afb  = 1'b0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      sel[i] = ({29'd0, motor} == 32'(i));
      if (sel[i]) begin
        cur_mag  = duty_magnitude[i];
        cur_pin  = pin_forward[i];
        cur_trav = travel_forward[i];
        cur_dest = destination[i];
        cur_afb  = approach_from_below[i];
      end
    end
    in_range = |sel;
  end

  always_comb begin
    mag_next  = cur_mag;
    pin_next  = cur_pin;
    trav_next = cur_trav;
    dest_next = cur_dest;
    afb_next  = cur_afb;
    limit_hit = (limit_near && cur_trav) || (limit_far && !cur_trav);
    reached   = cur_afb ? (encoder_count >= cur_dest) : (encoder_count <= cur_dest);
    stop      = 1'b0;
    unique case (kind)
      mmlsc_pkg::KIND_SET_DUTY_DIR: begin
        mag_next  = mmlsc_pkg::duty_magnitude_of(duty);
        pin_next  = !duty[mmlsc_pkg::DUTY_W-1] && (duty != '0);
        trav_next = pin_next;
      end
      mmlsc_pkg::KIND_SET_DUTY: begin
        mag_next = mmlsc_pkg::duty_magnitude_of(duty);
      end
      mmlsc_pkg::KIND_SET_DEST: begin
        afb_next  = encoder_count < target_position;
        trav_next = afb_next;
        dest_next = target_position;
      end
      mmlsc_pkg::KIND_TICK: begin
        stop = limit_hit || (position_stop_enable && reached);
        if (stop) begin
          mag_next  = '0;
          pin_next  = 1'b0;
          trav_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // An out-of-range motor leaves everything alone and reports all zeros.
    result.in_range  = in_range;
    result.magnitude = in_range ? mag_next : '0;
    result.forward   = in_range && pin_next;
    result.stopped   = in_range && stop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        duty_magnitude[i]      <= '0;
        pin_forward[i]         <= 1'b1;
        travel_forward[i]      <= 1'b1;
        destination[i]         <= mmlsc_pkg::RESET_DESTINATION;
        approach_from_below[i] <= 1'b1;
      end
    end else if (update) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        if (sel[i]) begin
          duty_magnitude[i]      <= mag_next;
          pin_forward[i]         <= pin_next;
          travel_forward[i]      <= trav_next;
          destination[i]         <= dest_next;
          approach_from_below[i] <= afb_next;
        end
      end
    end
  end

endmodule

// ----- rtl/mmlsc_pwm_scale.sv -----
// PWM compare scaling: ceil(PWM_TOP * magnitude / 2^16), saturated at PWM_TOP,
// truncated to the compare width. Depends on mmlsc_pkg for widths.
module mmlsc_pwm_scale #(
  parameter int PWM_TOP = 1023
) (
  input  logic [mmlsc_pkg::MAG_W-1:0]     magnitude,
  output logic [mmlsc_pkg::COMPARE_W-1:0] compare_value
);

  localparam logic [15:0] TOP = 16'(PWM_TOP);

  logic [33:0] product;
  logic [17:0] quotient;
  logic [17:0] saturated;

  always_comb begin
    product   = 34'(TOP) * 34'(magnitude) + 34'd65535;
    quotient  = product[33:16];
    saturated = (quotient > 18'(TOP)) ? 18'(TOP) : quotient;
    compare_value = saturated[mmlsc_pkg::COMPARE_W-1:0];
  end

endmodule

// ----- rtl/multi_motor_limit_stop_controller_top.sv -----
// Top level of the multi-motor limit-stop controller.
// Depends on mmlsc_pkg, mmlsc_motor_bank and mmlsc_pwm_scale.
//
// Usage:
// Each input transaction carries a kind, a motor index and the fields that kind
// uses (duty, target_position, encoder_count, limit switches). Every input
// transaction yields exactly one output transaction: the motor index, the PWM
// compare value and direction line now applied to that motor, and a flag that
// a tick forced a stop. Indexes at or above MOTOR_COUNT change nothing and
// report zeros.
// Each accepted transaction passes an input register, then the motor state
// read-modify-write and compare scaling, which land in the output register
// at the same edge. Throughput is one transaction per cycle while the
// receiver does not stall; the next item sees the state left by the one
// before it. When the receiver stalls, the output register holds its
// result and an empty input register can still take one more transaction
// before in_stall rises. The user must write position_stop_enable through
// cfg_write_enable/cfg_write_data only while the block is idle; the block does
// not enforce this. Synchronous reset empties both registers, clears the enable
// and returns every motor to zero duty, forward direction and destination 100 approached from below.
module multi_motor_limit_stop_controller_top #(
  parameter int MOTOR_COUNT = 5,
  parameter int PWM_TOP     = 1023
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic                                cfg_write_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [mmlsc_pkg::MOTOR_W-1:0]       motor,
  input  logic signed [mmlsc_pkg::DUTY_W-1:0] duty,
  input  logic [mmlsc_pkg::POS_W-1:0]         target_position,
  input  logic [mmlsc_pkg::POS_W-1:0]         encoder_count,
  input  logic                                limit_near,
  input  logic                                limit_far,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mmlsc_pkg::MOTOR_W-1:0]       motor_out,
  output logic [mmlsc_pkg::COMPARE_W-1:0]     compare_value,
  output logic                                forward,
  output logic                                stopped
);

  logic                           position_stop_enable;

  logic                           s1_valid;
  mmlsc_pkg::kind_t               s1_kind;
  logic [mmlsc_pkg::MOTOR_W-1:0]  s1_motor;
  logic [mmlsc_pkg::DUTY_W-1:0]   s1_duty;
  logic [mmlsc_pkg::POS_W-1:0]    s1_target;
  logic [mmlsc_pkg::POS_W-1:0]    s1_encoder;
  logic                           s1_near;
  logic                           s1_far;

  logic                           advance;
  mmlsc_pkg::bank_result_t        bank_result;
  logic [mmlsc_pkg::COMPARE_W-1:0] compare_next;

  // The output register can load when it is empty or its result is being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_stop_enable <= 1'b0;
    end else if (cfg_write_enable) begin
      position_stop_enable <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind    <= mmlsc_pkg::kind_t'(kind);
      s1_motor   <= motor;
      s1_duty    <= duty;
      s1_target  <= target_position;
      s1_encoder <= encoder_count;
      s1_near    <= limit_near;
      s1_far     <= limit_far;
    end
  end

  mmlsc_motor_bank #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_bank (
    .clk                  (clk),
    .rst                  (rst),
    .update               (s1_valid && advance),
    .position_stop_enable (position_stop_enable),
    .kind                 (s1_kind),
    .motor                (s1_motor),
    .duty                 (s1_duty),
    .target_position      (s1_target),
    .encoder_count        (s1_encoder),
    .limit_near           (s1_near),
    .limit_far            (s1_far),
    .result               (bank_result)
  );

  mmlsc_pwm_scale #(
    .PWM_TOP(PWM_TOP)
  ) u_scale (
    .magnitude     (bank_result.magnitude),
    .compare_value (compare_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      motor_out     <= s1_motor;
      compare_value <= compare_next;
      forward       <= bank_result.forward;
      stopped       <= bank_result.stopped;
    end
  end

endmodule

// ----- rtl/mmlsc_checker.sv -----
// Port-level checks for the multi-motor limit-stop controller, bound to the top level.
// Depends only on the top level's ports and mmlsc_pkg widths.
module mmlsc_checker #(
  parameter int MOTOR_COUNT = 5
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [mmlsc_pkg::MOTOR_W-1:0]       motor_out,
  input logic [mmlsc_pkg::COMPARE_W-1:0]     compare_value,
  input logic                                forward,
  input logic                                stopped
);

  // A stalled result stays on the port unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(motor_out) && $stable(compare_value)
      && $stable(forward) && $stable(stopped))
    else $error("stalled output transaction changed or dropped");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A forced stop leaves the motor with zero duty and reverse direction.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stopped |-> compare_value == '0 && !forward)
    else $error("stopped motor still driven");

  // An index beyond the motor count reports an idle motor.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && ({29'd0, motor_out} >= 32'(MOTOR_COUNT))
      |-> compare_value == '0 && !forward && !stopped)
    else $error("out-of-range motor reported activity");

endmodule

bind multi_motor_limit_stop_controller_top mmlsc_checker #(
  .MOTOR_COUNT(MOTOR_COUNT)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .motor_out     (motor_out),
  .compare_value (compare_value),
  .forward       (forward),
  .stopped       (stopped)
);
